>>> hdl/psr_pkg.sv
// Package for the polyphase stereo resampler: default sizes, fixed field widths,
// limits and the sequencer state type. No dependencies.
package psr_pkg;
    localparam int TAPS_DEF          = 32;
    localparam int HISTORY_DEPTH_DEF = 128;
    localparam int PHASES_DEF        = 256;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_ADR_W = 13;
    localparam int RATE_W     = 19;
    localparam int LAG_W      = 10;
    localparam int MAX_OUT    = 64;
    localparam int OUT_CNT_W  = 7;

    localparam logic [RATE_W-1:0] RATE_RESET = 19'd65536;
    localparam logic [LAG_W-1:0]  LAG_MAX    = 10'd1023;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_MAC   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;
endpackage

>>> hdl/psr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module psr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/polyphase_stereo_resampler_top.sv
// Top level of the polyphase stereo resampler: sequencer, MAC pipeline, history
// and coefficient memories. Depends on psr_pkg and psr_ram.
//
// Usage. Input transactions arrive on the i_s_axis group. tuser carries func:
// 0 means tdata holds a stereo frame, 1 means tdata holds one coefficient word
// for the loadable bank. A coefficient load causes no output. A frame is
// written into the history ring, and then every output frame that is due is
// produced on the o_m_axis group, with tlast high on the final one caused by
// that frame. Each output passes through selection of the coefficient row,
// multiply-accumulate over TAPS taps (one history read and one coefficient read
// per cycle, the memory read ports set the pace) and the output register, in
// which it is held until it is taken. One input transaction is worked on at a
// time; i_s_axis_tready is low until all its outputs are taken. When the
// receiver stalls, the output register holds its frame and the sequencer
// waits. Reset clears the ring (through per-slot valid bits, so it reads as
// silence at once), the phase, the write and read slot pointers and sets
// rate_step to 1.0. The configuration channel (i_cfg_*) writes rate_step in
// unsigned Q3.16 and is always ready; the user must write it only while the
// block is idle, and the block itself does not enforce this.
module polyphase_stereo_resampler_top #(
    parameter int TAPS          = psr_pkg::TAPS_DEF,
    parameter int HISTORY_DEPTH = psr_pkg::HISTORY_DEPTH_DEF,
    parameter int PHASES        = psr_pkg::PHASES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata from bit 0: left_in[15:0], right_in[15:0], coef_address[12:0],
    // coef_value[15:0], zero fill [63:61]
    input  logic [63:0] i_s_axis_tdata,
    // tuser: func
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata from bit 0: left_out[15:0], right_out[15:0]
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [psr_pkg::RATE_W-1:0] i_cfg_data
);
    import psr_pkg::*;

    localparam int HW    = $clog2(HISTORY_DEPTH);
    localparam int BANK  = PHASES * TAPS;
    localparam int CAW   = $clog2(BANK);
    localparam int RW    = $clog2(PHASES);
    localparam int TCW   = $clog2(TAPS + 1);
    localparam int ACC_W = 2 * SAMPLE_W + $clog2(TAPS) + 1;
    localparam int HALF  = TAPS / 2;
    localparam int BACK  = TAPS / 2 - 1;

    // Input field unpacking.
    logic signed [SAMPLE_W-1:0] w_left_in, w_right_in, w_coef_value;
    logic [COEF_ADR_W-1:0]      w_coef_address;
    assign w_left_in      = i_s_axis_tdata[15:0];
    assign w_right_in     = i_s_axis_tdata[31:16];
    assign w_coef_address = i_s_axis_tdata[44:32];
    assign w_coef_value   = i_s_axis_tdata[60:45];

    t_state r_state;
    logic [RATE_W-1:0]    r_rate;
    logic [HW-1:0]        r_wr_slot, r_rd_slot, r_tap_slot;
    logic [LAG_W-1:0]     r_ahead;
    logic [15:0]          r_phase;
    logic [OUT_CNT_W-1:0] r_n_out;
    logic [CAW-1:0]       r_coef_base;
    logic [TCW-1:0]       r_issue;
    logic                 r_v1, r_v2;
    logic [HISTORY_DEPTH-1:0] r_hist_valid;
    logic                 r_hv;
    logic signed [2*SAMPLE_W-1:0] r_prod_l, r_prod_r;
    logic signed [ACC_W-1:0]      r_acc_l, r_acc_r;
    logic [31:0]          r_out_data;

    wire w_in_hs  = i_s_axis_tvalid && o_s_axis_tready;
    wire w_out_hs = o_m_axis_tvalid && i_m_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // History memory: one stereo frame per slot.
    logic          w_hist_we;
    logic [31:0]   w_hist_rdata;
    assign w_hist_we = w_in_hs && !i_s_axis_tuser;

    psr_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk  (i_clk),
        .i_we   (w_hist_we),
        .i_waddr(r_wr_slot),
        .i_wdata({w_right_in, w_left_in}),
        .i_raddr(r_tap_slot),
        .o_rdata(w_hist_rdata)
    );

    // Coefficient bank; addresses beyond the bank are dropped.
    logic                       w_coef_we;
    logic [CAW-1:0]             w_coef_raddr;
    logic signed [SAMPLE_W-1:0] w_coef_rdata;
    assign w_coef_we    = w_in_hs && i_s_axis_tuser && (32'(w_coef_address) < BANK);
    assign w_coef_raddr = r_coef_base + CAW'(r_issue);

    psr_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK)) u_coef (
        .i_clk  (i_clk),
        .i_we   (w_coef_we),
        .i_waddr(CAW'(w_coef_address)),
        .i_wdata(w_coef_value),
        .i_raddr(w_coef_raddr),
        .o_rdata(w_coef_rdata)
    );

    // Samples from never-written slots read as silence.
    logic signed [SAMPLE_W-1:0] w_samp_l, w_samp_r;
    assign w_samp_l = r_hv ? w_hist_rdata[15:0]  : '0;
    assign w_samp_r = r_hv ? w_hist_rdata[31:16] : '0;

    // Phase step and the lag that results after the output now shown.
    logic [19:0]      w_phase_sum;
    logic [3:0]       w_adv;
    logic [LAG_W-1:0] w_ahead_next;
    logic [HW:0]      w_rd_sum;
    logic             w_more;
    assign w_phase_sum  = 20'(r_phase) + 20'(r_rate);
    assign w_adv        = w_phase_sum[19:16];
    assign w_ahead_next = r_ahead - LAG_W'(w_adv);
    assign w_rd_sum     = (HW+1)'(r_rd_slot) + (HW+1)'(w_adv);
    assign w_more       = (32'(w_ahead_next) > HALF) &&
                          (32'(r_n_out) + 1 < MAX_OUT);
    assign o_m_axis_tlast = !w_more;

    // Row select and tap window start.
    logic [RW-1:0] w_row;
    logic [HW-1:0] w_base;
    assign w_row  = RW'((32'(r_phase) * PHASES) >> 16);
    assign w_base = (32'(r_rd_slot) >= BACK) ? HW'(32'(r_rd_slot) - BACK)
                                             : HW'(32'(r_rd_slot) + HISTORY_DEPTH - BACK);

    // Rounding half up and saturation.
    function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] q;
        q = ($signed({acc[ACC_W-1], acc}) + (ACC_W+1)'(16'sh4000)) >>> 15;
        if (q > 32767) begin
            round_sat = 16'h7FFF;
        end else if (q < -32768) begin
            round_sat = 16'h8000;
        end else begin
            round_sat = q[SAMPLE_W-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rate       <= RATE_RESET;
            r_wr_slot    <= '0;
            r_rd_slot    <= '0;
            r_ahead      <= '0;
            r_phase      <= '0;
            r_n_out      <= '0;
            r_issue      <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_hist_valid <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_rate <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_hist_we) begin
                        r_hist_valid[r_wr_slot] <= 1'b1;
                        r_wr_slot <= (32'(r_wr_slot) == HISTORY_DEPTH - 1) ? '0
                                                                           : r_wr_slot + 1'b1;
                        if (r_ahead < LAG_MAX) begin
                            r_ahead <= r_ahead + 1'b1;
                        end
                        r_n_out <= '0;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if ((32'(r_ahead) > HALF) && (32'(r_n_out) < MAX_OUT)) begin
                        r_coef_base <= CAW'(32'(w_row) * TAPS);
                        r_tap_slot  <= w_base;
                        r_issue     <= '0;
                        r_acc_l     <= '0;
                        r_acc_r     <= '0;
                        r_state     <= ST_MAC;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_MAC: begin
                    // Issue one tap read per cycle; data, product, accumulate follow.
                    r_v1 <= (32'(r_issue) < TAPS);
                    if (32'(r_issue) < TAPS) begin
                        r_hv       <= r_hist_valid[r_tap_slot];
                        r_issue    <= r_issue + 1'b1;
                        r_tap_slot <= (32'(r_tap_slot) == HISTORY_DEPTH - 1) ? '0
                                                                             : r_tap_slot + 1'b1;
                    end
                    r_v2 <= r_v1;
                    if (r_v1) begin
                        r_prod_l <= w_samp_l * w_coef_rdata;
                        r_prod_r <= w_samp_r * w_coef_rdata;
                    end
                    if (r_v2) begin
                        r_acc_l <= r_acc_l + ACC_W'(r_prod_l);
                        r_acc_r <= r_acc_r + ACC_W'(r_prod_r);
                    end
                    if ((32'(r_issue) == TAPS) && !r_v1 && !r_v2) begin
                        r_out_data <= {round_sat(r_acc_r), round_sat(r_acc_l)};
                        r_state    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_hs) begin
                        r_phase   <= w_phase_sum[15:0];
                        r_ahead   <= w_ahead_next;
                        r_rd_slot <= (32'(w_rd_sum) >= HISTORY_DEPTH)
                                     ? HW'(32'(w_rd_sum) - HISTORY_DEPTH) : HW'(w_rd_sum);
                        r_n_out   <= r_n_out + 1'b1;
                        r_state   <= ST_CHECK;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The pipeline only runs while a dot product is in progress.
    a_pipe_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> (r_state == ST_MAC))
        else $error("MAC pipeline active outside MAC state");

    // No new input while an output is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input accepted while output pending");

    // A final output returns the block to idle by way of the check state.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_hs && o_m_axis_tlast) |=> ##1 (r_state == ST_IDLE))
        else $error("block not idle after last output");

    // Never more than the allowed outputs per input.
    a_out_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_n_out) <= MAX_OUT)
        else $error("output count exceeded");
endmodule
